// ----- hdl/sorted_priority_queue_unit_macros.svh -----
// Assertion macros shared by the priority queue RTL.
// Define ASSERT_OFF to compile the assertions away.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SPQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
`else
`define SPQ_ASSERT(label, expr, msg)
`define SPQ_ASSERT_NEXT(label, cond, conseq, msg)
`endif

`endif

// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PLACE,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t                kind;
    logic [31:0]        item_in;
    logic signed [15:0] priority_in;
  } req_t;

  typedef struct packed {
    logic [31:0] item_out;
    status_t     status;
    logic        empty_res;
    logic [4:0]  occupancy;
  } rsp_t;

endpackage

// ----- hdl/spq_chan_if.sv -----
`timescale 1ns / 1ps

interface spq_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Sorted priority queue. Requests arrive on req (valid/ready, spq_pkg::req_t):
// insert, pop head, peek head, or delete the first entry matching both item
// and priority. Every request gives exactly one result on rsp (rsp_t) with
// the head item, a status, the empty flag and the occupancy after the request.
// Entries are kept in descending priority order in a one-write, one-read
// memory; equal priorities stay in arrival order.
// The list is walked one entry per cycle through the memory port.
// Peek and requests on an empty or full queue skip the walk and go straight
// to the output register. Pop and delete walk every entry; an insert into a
// non-empty queue walks from the tail to an entry of equal or higher priority, or to the head.
// The next request is taken once the walk is over, while the previous result
// may still sit in the output register; a stalled receiver holds the block in
// its last step until the output register frees.
// Reset (synchronous, active high) empties the queue at once; memory contents
// are not cleared, since only entries below the count are ever read.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  spq_chan_if.sink    req,
  spq_chan_if.source  rsp
);

  `include "sorted_priority_queue_unit_macros.svh"

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [ITEM_BITS-1:0] item;
    logic signed [15:0]   prio;
  } entry_t;

  entry_t mem [DEPTH];
  entry_t rd_data;
  entry_t wd;
  logic [IW-1:0] wa;
  logic [IW-1:0] ra;
  logic          we;

  state_t state, state_next;
  op_t    kind, kind_next;
  logic [ITEM_BITS-1:0] key_item, key_item_next;
  logic signed [15:0]   key_prio, key_prio_next;
  logic [ITEM_BITS-1:0] head, head_next;
  logic [ITEM_BITS-1:0] res_item, res_item_next;
  logic [IW-1:0] cur, cur_next;
  logic [CW-1:0] count, count_next;
  logic          found, found_next;
  status_t       status, status_next;
  logic          out_valid, out_valid_next;
  rsp_t          out_data, out_data_next;

  logic                 hit;
  logic                 last;
  logic [ITEM_BITS-1:0] sel_item;
  logic [63:0]          item_wide;
  entry_t               key_entry;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      found     <= found_next;
    end
    kind     <= kind_next;
    key_item <= key_item_next;
    key_prio <= key_prio_next;
    head     <= head_next;
    res_item <= res_item_next;
    cur      <= cur_next;
    status   <= status_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    kind_next      = kind;
    key_item_next  = key_item;
    key_prio_next  = key_prio;
    head_next      = head;
    res_item_next  = res_item;
    cur_next       = cur;
    count_next     = count;
    found_next     = found;
    status_next    = status;
    out_valid_next = out_valid && !rsp.ready;
    out_data_next  = out_data;
    key_entry.item = key_item;
    key_entry.prio = key_prio;
    we             = 1'b0;
    wa             = '0;
    wd             = key_entry;
    ra             = cur;
    hit            = (kind == OP_POP && cur == '0) ||
                     (rd_data.item == key_item && rd_data.prio == key_prio);
    last           = (CW'(cur) + CW'(1) == count);
    sel_item       = '0;
    item_wide      = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_next     = req.data.kind;
          key_item_next = ITEM_BITS'(req.data.item_in);
          key_prio_next = req.data.priority_in;
          status_next   = ST_OK;
          found_next    = 1'b0;
          unique case (req.data.kind)
            OP_INSERT: begin
              if (count == CW'(DEPTH)) begin
                status_next = ST_FULL;
                state_next  = S_FINISH;
              end else if (count == '0) begin
                we         = 1'b1;
                wa         = '0;
                wd.item    = ITEM_BITS'(req.data.item_in);
                wd.prio    = req.data.priority_in;
                head_next  = ITEM_BITS'(req.data.item_in);
                count_next = CW'(1);
                state_next = S_FINISH;
              end else begin
                // Walk from the tail toward the head, moving entries up.
                ra         = IW'(count - CW'(1));
                cur_next   = IW'(count - CW'(1));
                state_next = S_WALK;
              end
            end
            OP_POP, OP_DELETE: begin
              if (count == '0) begin
                status_next   = (req.data.kind == OP_POP) ? ST_EMPTY : ST_NOMATCH;
                res_item_next = '0;
                state_next    = S_FINISH;
              end else begin
                res_item_next = head;
                ra            = '0;
                cur_next      = '0;
                state_next    = S_WALK;
              end
            end
            OP_PEEK: begin
              status_next   = (count == '0) ? ST_EMPTY : ST_OK;
              res_item_next = (count == '0) ? '0 : head;
              state_next    = S_FINISH;
            end
          endcase
        end
      end

      S_WALK: begin
        if (kind == OP_INSERT) begin
          we = 1'b1;
          wa = cur + IW'(1);
          if ($signed(rd_data.prio) >= $signed(key_prio)) begin
            // The new pair goes right behind this entry.
            wd         = key_entry;
            count_next = count + CW'(1);
            state_next = S_FINISH;
          end else begin
            wd = rd_data;
            if (cur == '0) begin
              state_next = S_PLACE;
            end else begin
              ra       = cur - IW'(1);
              cur_next = cur - IW'(1);
            end
          end
        end else begin
          // Once the match is found, every later entry moves down by one.
          if (found) begin
            we = 1'b1;
            wa = cur - IW'(1);
            wd = rd_data;
            if (cur == IW'(1)) begin
              head_next = rd_data.item;
            end
          end
          found_next = found || hit;
          if (last) begin
            if (found || hit) begin
              count_next = count - CW'(1);
            end else begin
              status_next = ST_NOMATCH;
            end
            state_next = S_FINISH;
          end else begin
            ra       = cur + IW'(1);
            cur_next = cur + IW'(1);
          end
        end
      end

      S_PLACE: begin
        we         = 1'b1;
        wa         = '0;
        wd         = key_entry;
        head_next  = key_item;
        count_next = count + CW'(1);
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (kind == OP_POP || kind == OP_PEEK) begin
          sel_item = res_item;
        end else begin
          sel_item = (count == '0) ? '0 : head;
        end
        item_wide = 64'(sel_item);
        if (!out_valid || rsp.ready) begin
          out_valid_next          = 1'b1;
          out_data_next.item_out  = item_wide[31:0];
          out_data_next.status    = status;
          out_data_next.empty_res = (count == '0);
          out_data_next.occupancy = 5'(count);
          state_next              = S_IDLE;
        end
      end
    endcase
  end

  `SPQ_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count exceeds DEPTH")
  `SPQ_ASSERT(a_write_in_range, !we || CW'(wa) <= count, "write beyond the list tail")
  `SPQ_ASSERT_NEXT(a_full_insert_drops, req.valid && req.ready && req.data.kind == OP_INSERT && count == CW'(DEPTH), count == $past(count), "insert into full queue changed the count")
  `SPQ_ASSERT_NEXT(a_occupancy_matches, state == S_FINISH && (!out_valid || rsp.ready), out_data.occupancy == 5'(count), "reported occupancy differs from count")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int DEPTH = 16;

  logic clk;
  logic rst;

  spq_chan_if #(.payload_t(req_t)) req_ch ();
  spq_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  sorted_priority_queue_unit #(
    .DEPTH(DEPTH),
    .ITEM_BITS(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the queue contents, kept in descending priority order.
  logic [31:0] shadow_items [DEPTH];
  shortint     shadow_prios [DEPTH];
  int          shadow_count;

  rsp_t expected_results[$];
  int   mismatch_count;
  bit   send_idle;
  bit   recv_idle;
  int   send_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < shadow_count; i++) begin
      shadow_items[i] = shadow_items[i + 1];
      shadow_prios[i] = shadow_prios[i + 1];
    end
    shadow_count--;
  endfunction

  // Applies one request to the shadow queue and returns the result it must give.
  function automatic rsp_t queue_apply(input req_t r);
    rsp_t    res;
    int      pos;
    int      i;
    shortint prio;
    prio = r.priority_in;
    res = '0;
    res.status = ST_OK;
    case (r.kind)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // New entry goes behind every entry of equal or higher priority.
          pos = 0;
          while (pos < shadow_count && shadow_prios[pos] >= prio) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_items[i] = shadow_items[i - 1];
            shadow_prios[i] = shadow_prios[i - 1];
          end
          shadow_items[pos] = r.item_in;
          shadow_prios[pos] = prio;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_out = shadow_items[0];
          drop_entry(0);
        end
      end
      OP_PEEK: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
      end
      default: begin
        pos = 0;
        while (pos < shadow_count &&
               !(shadow_items[pos] == r.item_in && shadow_prios[pos] == prio)) pos++;
        if (pos < shadow_count) drop_entry(pos);
        else res.status = ST_NOMATCH;
      end
    endcase
    // Everything but pop reports the head as it stands afterwards.
    if (r.kind != OP_POP) res.item_out = (shadow_count != 0) ? shadow_items[0] : '0;
    res.empty_res = (shadow_count == 0);
    res.occupancy = 5'(shadow_count);
    return res;
  endfunction

  // Valid stays high into the next request when no gap was drawn, so it is
  // only lowered here when the following request will wait.
  task automatic send_req(input op_t kind, input logic [31:0] item, input shortint prio);
    req_t r;
    r.kind = kind;
    r.item_in = item;
    r.priority_in = prio;
    repeat (send_gap) @(posedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_results.push_back(queue_apply(r));
    send_gap = send_idle ? $urandom_range(0, 7) : 0;
    if (send_gap != 0) req_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    if (send_gap == 0) req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_item();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Priorities cluster in a narrow band so that ties are frequent.
  function automatic shortint pick_priority();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2, 3, 4, 5: return shortint'(int'($urandom_range(0, 6)) - 3);
      default: return shortint'($urandom);
    endcase
  endfunction

  task automatic test_empty_queue();
    send_req(OP_POP, 32'hFFFF_FFFF, 16'sh7FFF);
    send_req(OP_PEEK, 32'h0000_0000, -16'sh8000);
    send_req(OP_DELETE, 32'h0000_0000, 16'sh0000);
    settle();
  endtask

  task automatic test_ordering();
    send_req(OP_INSERT, 32'h0000_00A5, 16'sd5);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 16'sh7FFF);
    send_req(OP_INSERT, 32'h0000_0000, -16'sh8000);
    send_req(OP_INSERT, 32'h1234_5678, 16'sd5);
    send_req(OP_INSERT, 32'h0000_00A5, 16'sd5);
    send_req(OP_PEEK, 32'h0, 16'sd0);
    send_req(OP_DELETE, 32'h0000_00A5, 16'sd5);
    send_req(OP_DELETE, 32'h0000_00A5, 16'sd4);
    send_req(OP_POP, 32'h0, 16'sd0);
    send_req(OP_DELETE, 32'h0000_0000, -16'sh8000);
    settle();
  endtask

  task automatic test_full_queue();
    while (shadow_count < DEPTH) send_req(OP_INSERT, pick_item(), pick_priority());
    send_req(OP_INSERT, 32'hDEAD_BEEF, 16'sh7FFF);
    send_req(OP_POP, 32'h0, 16'sd0);
    settle();
  endtask

  // Deletes mostly name a pair that is held, so that matches sit at every depth.
  task automatic test_random(input int count, input int ins_pct, input int pop_pct,
                             input bit idle_in, input bit idle_out);
    int      k;
    int      roll;
    int      idx;
    shortint prio;
    logic [31:0] item;
    send_idle = idle_in;
    recv_idle = idle_out;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      item = pick_item();
      prio = pick_priority();
      if (roll < ins_pct) begin
        send_req(OP_INSERT, item, prio);
      end else if (roll < ins_pct + pop_pct) begin
        send_req(OP_POP, item, prio);
      end else if (roll[0]) begin
        send_req(OP_PEEK, item, prio);
      end else begin
        if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, shadow_count - 1);
          item = shadow_items[idx];
          prio = shadow_prios[idx];
          if ($urandom_range(0, 4) == 0) prio = prio + 16'sd1;
        end
        send_req(OP_DELETE, item, prio);
      end
    end
    settle();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin : result_checker
    int   stall;
    rsp_t exp;
    forever begin
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1 || rst);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item %h status %0d empty %b count %0d", $time,
                 rsp_ch.data.item_out, rsp_ch.data.status, rsp_ch.data.empty_res,
                 rsp_ch.data.occupancy);
        mismatch_count++;
      end else begin
        exp = expected_results.pop_front();
        if (rsp_ch.data !== exp) begin
          $display("%0t: expected item %h status %0d empty %b count %0d, got item %h status %0d empty %b count %0d",
                   $time, exp.item_out, exp.status, exp.empty_res, exp.occupancy,
                   rsp_ch.data.item_out, rsp_ch.data.status, rsp_ch.data.empty_res,
                   rsp_ch.data.occupancy);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    shadow_count = 0;
    mismatch_count = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_gap = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_ordering();
    test_full_queue();
    test_random(150, 75, 10, 1'b1, 1'b1);
    test_random(150, 15, 65, 1'b1, 1'b1);
    test_random(120, 45, 25, 1'b0, 1'b0);
    test_random(100, 50, 25, 1'b1, 1'b0);
    test_random(100, 40, 35, 1'b0, 1'b1);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
